FILE: rtl/bos_platform_capability_parser_assert.svh
// Assertion macros for the RTL of the BOS platform capability parser.
// When SYNTH is defined, every macro expands to nothing.
`ifndef BOS_PLATFORM_CAPABILITY_PARSER_ASSERT_SVH
`define BOS_PLATFORM_CAPABILITY_PARSER_ASSERT_SVH

`ifndef SYNTH

// If the antecedent holds, the consequent must hold in the same cycle.
`define BPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// If the antecedent holds, the consequent must hold in the next cycle.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/bpc_pkg.sv
package bpc_pkg;

    // Verdict codes of the capability walk.
    localparam logic [1:0] VERDICT_PENDING = 2'd0;
    localparam logic [1:0] VERDICT_FOUND   = 2'd1;
    localparam logic [1:0] VERDICT_FAILED  = 2'd2;

    // Descriptor constants.
    localparam logic [7:0]  BOS_HDR_LENGTH    = 8'h05;
    localparam logic [7:0]  BOS_DESC_TYPE     = 8'h0F;
    localparam logic [7:0]  CAP_DESC_TYPE     = 8'h10;
    localparam logic [7:0]  CAP_TYPE_PLATFORM = 8'h05;
    localparam logic [7:0]  CAP_MIN_LENGTH    = 8'd3;
    localparam logic [7:0]  PLATFORM_MIN_LEN  = 8'd20;
    localparam logic [7:0]  WEBUSB_MIN_LEN    = 8'd22;
    localparam logic [7:0]  WEBUSB_LEN        = 8'd24;
    localparam logic [15:0] WEBUSB_MIN_VER    = 16'h0100;

    // Byte offsets inside a capability descriptor.
    localparam logic [7:0] OFF_LENGTH  = 8'd0;
    localparam logic [7:0] OFF_TYPE    = 8'd1;
    localparam logic [7:0] OFF_CAPTYPE = 8'd2;
    localparam logic [7:0] OFF_UUID_LO = 8'd4;
    localparam logic [7:0] OFF_UUID_HI = 8'd19;
    localparam logic [7:0] OFF_VER_LO  = 8'd20;
    localparam logic [7:0] OFF_VER_HI  = 8'd21;
    localparam logic [7:0] OFF_VENDOR  = 8'd22;
    localparam logic [7:0] OFF_LANDING = 8'd23;

    // One result word.
    typedef struct packed {
        logic        found;
        logic [15:0] version;
        logic [7:0]  vendor;
        logic [7:0]  landing;
    } result_t;

    // WebUSB platform capability UUID, in wire order.
    function automatic logic [7:0] uuid_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h38;
            4'd1:    b = 8'hB6;
            4'd2:    b = 8'h08;
            4'd3:    b = 8'h34;
            4'd4:    b = 8'hA9;
            4'd5:    b = 8'h09;
            4'd6:    b = 8'hA0;
            4'd7:    b = 8'h47;
            4'd8:    b = 8'h8B;
            4'd9:    b = 8'hFD;
            4'd10:   b = 8'hA0;
            4'd11:   b = 8'h76;
            4'd12:   b = 8'h88;
            4'd13:   b = 8'h15;
            4'd14:   b = 8'hB6;
            4'd15:   b = 8'h65;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/bpc_scan.sv
module bpc_scan
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data,
    input  logic                 last,
    output bpc_pkg::result_t     result
);

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [15:0] total_reg;
    logic [15:0] total_next;
    logic [7:0]  caps_reg;
    logic [7:0]  caps_next;
    logic [7:0]  off_reg;
    logic [7:0]  off_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic        plat_reg;
    logic        plat_next;
    logic        uuid_ok_reg;
    logic        uuid_ok_next;
    logic [1:0]  verdict_reg;
    logic [1:0]  verdict_next;
    logic [15:0] ver_reg;
    logic [15:0] ver_next;
    logic [7:0]  vendor_reg;
    logic [7:0]  vendor_next;
    logic [7:0]  landing_reg;
    logic [7:0]  landing_next;

    logic [15:0] room;
    logic [16:0] pos_inc;
    logic [3:0]  uuid_idx;
    logic [7:0]  off_inc;
    logic [7:0]  caps_dec;
    logic        stop;
    logic        ok;

    assign room     = total_reg - pos_reg;
    assign pos_inc  = {1'b0, pos_reg} + 17'd1;
    assign uuid_idx = off_reg[3:0] - 4'd4;
    assign off_inc  = off_reg + 8'd1;
    assign caps_dec = caps_reg - 8'd1;

    // Per-byte update of the header check and the capability walk.
    always_comb
    begin
        total_next   = total_reg;
        caps_next    = caps_reg;
        off_next     = off_reg;
        len_next     = len_reg;
        plat_next    = plat_reg;
        uuid_ok_next = uuid_ok_reg;
        verdict_next = verdict_reg;
        ver_next     = ver_reg;
        vendor_next  = vendor_reg;
        landing_next = landing_reg;
        stop         = 1'b0;

        if (verdict_reg == bpc_pkg::VERDICT_PENDING)
        begin
            if (pos_reg == 16'd0)
            begin
                if (data != bpc_pkg::BOS_HDR_LENGTH)
                    verdict_next = bpc_pkg::VERDICT_FAILED;
            end
            else if (pos_reg == 16'd1)
            begin
                if (data != bpc_pkg::BOS_DESC_TYPE)
                    verdict_next = bpc_pkg::VERDICT_FAILED;
            end
            else if (pos_reg == 16'd2)
            begin
                total_next = {8'd0, data};
            end
            else if (pos_reg == 16'd3)
            begin
                total_next = {data, total_reg[7:0]};
                if ({data, total_reg[7:0]} < 16'd5)
                    verdict_next = bpc_pkg::VERDICT_FAILED;
            end
            else if (pos_reg == 16'd4)
            begin
                caps_next = data;
                if (data == 8'd0 || total_reg == 16'd5)
                    verdict_next = bpc_pkg::VERDICT_FAILED;
            end
            else if (pos_reg < total_reg)
            begin
                // Capability body.
                if (off_reg == bpc_pkg::OFF_LENGTH)
                begin
                    len_next = data;
                    if (data < bpc_pkg::CAP_MIN_LENGTH || {8'd0, data} > room)
                    begin
                        verdict_next = bpc_pkg::VERDICT_FAILED;
                        stop         = 1'b1;
                    end
                end
                else if (off_reg == bpc_pkg::OFF_TYPE)
                begin
                    if (data != bpc_pkg::CAP_DESC_TYPE)
                    begin
                        verdict_next = bpc_pkg::VERDICT_FAILED;
                        stop         = 1'b1;
                    end
                end
                else if (off_reg == bpc_pkg::OFF_CAPTYPE)
                begin
                    plat_next = (data == bpc_pkg::CAP_TYPE_PLATFORM);
                    if (data == bpc_pkg::CAP_TYPE_PLATFORM &&
                        len_reg < bpc_pkg::PLATFORM_MIN_LEN)
                    begin
                        verdict_next = bpc_pkg::VERDICT_FAILED;
                        stop         = 1'b1;
                    end
                end
                else if (plat_reg)
                begin
                    if (off_reg >= bpc_pkg::OFF_UUID_LO && off_reg <= bpc_pkg::OFF_UUID_HI)
                    begin
                        uuid_ok_next = uuid_ok_reg && (data == bpc_pkg::uuid_byte(uuid_idx));
                        if (off_reg == bpc_pkg::OFF_UUID_HI)
                        begin
                            if (!uuid_ok_next)
                                plat_next = 1'b0;
                            else if (len_reg < bpc_pkg::WEBUSB_MIN_LEN)
                            begin
                                verdict_next = bpc_pkg::VERDICT_FAILED;
                                stop         = 1'b1;
                            end
                        end
                    end
                    else if (off_reg == bpc_pkg::OFF_VER_LO)
                    begin
                        ver_next = {ver_reg[15:8], data};
                    end
                    else if (off_reg == bpc_pkg::OFF_VER_HI)
                    begin
                        ver_next = {data, ver_reg[7:0]};
                        if ({data, ver_reg[7:0]} < bpc_pkg::WEBUSB_MIN_VER)
                            plat_next = 1'b0;
                        else if (len_reg != bpc_pkg::WEBUSB_LEN)
                        begin
                            verdict_next = bpc_pkg::VERDICT_FAILED;
                            stop         = 1'b1;
                        end
                    end
                    else if (off_reg == bpc_pkg::OFF_VENDOR)
                    begin
                        vendor_next = data;
                    end
                    else if (off_reg == bpc_pkg::OFF_LANDING)
                    begin
                        landing_next = data;
                        verdict_next = bpc_pkg::VERDICT_FOUND;
                        stop         = 1'b1;
                    end
                end

                // Step to the next byte, or close this capability.
                if (!stop)
                begin
                    off_next = off_inc;
                    if (off_inc == len_next)
                    begin
                        caps_next = caps_dec;
                        if (caps_dec == 8'd0 || pos_inc == {1'b0, total_reg})
                        begin
                            verdict_next = bpc_pkg::VERDICT_FAILED;
                        end
                        else
                        begin
                            off_next     = bpc_pkg::OFF_LENGTH;
                            plat_next    = 1'b0;
                            uuid_ok_next = 1'b1;
                        end
                    end
                end
            end
        end

        pos_next = (pos_reg == 16'hFFFF) ? pos_reg : pos_inc[15:0];

        // Result as seen after this byte.
        ok = (verdict_next == bpc_pkg::VERDICT_FOUND) && (pos_next >= 16'd5) &&
             (pos_next >= total_next);
        result.found   = ok;
        result.version = ok ? ver_next : 16'd0;
        result.vendor  = ok ? vendor_next : 8'd0;
        result.landing = ok ? landing_next : 8'd0;

        // The final byte returns every register to its reset value.
        if (last)
        begin
            pos_next     = 16'd0;
            total_next   = 16'd0;
            caps_next    = 8'd0;
            off_next     = 8'd0;
            len_next     = 8'd0;
            plat_next    = 1'b0;
            uuid_ok_next = 1'b1;
            verdict_next = bpc_pkg::VERDICT_PENDING;
            ver_next     = 16'd0;
            vendor_next  = 8'd0;
            landing_next = 8'd0;
        end
    end

    // Walk state, updated once for each byte that leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 16'd0;
            total_reg   <= 16'd0;
            caps_reg    <= 8'd0;
            off_reg     <= 8'd0;
            len_reg     <= 8'd0;
            plat_reg    <= 1'b0;
            uuid_ok_reg <= 1'b1;
            verdict_reg <= bpc_pkg::VERDICT_PENDING;
            ver_reg     <= 16'd0;
            vendor_reg  <= 8'd0;
            landing_reg <= 8'd0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            caps_reg    <= caps_next;
            off_reg     <= off_next;
            len_reg     <= len_next;
            plat_reg    <= plat_next;
            uuid_ok_reg <= uuid_ok_next;
            verdict_reg <= verdict_next;
            ver_reg     <= ver_next;
            vendor_reg  <= vendor_next;
            landing_reg <= landing_next;
        end
    end

endmodule

FILE: rtl/bpc_out.sv
module bpc_out
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  bpc_pkg::result_t     result,
    input  logic                 take,
    output logic                 full,
    output bpc_pkg::result_t     held
);

    logic             valid_reg;
    logic             valid_next;
    bpc_pkg::result_t data_reg;

    // Slot is occupied until the downstream side takes the word.
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Result payload, loaded only when a word is written.
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign full = valid_reg;
    assign held = data_reg;

endmodule

FILE: rtl/bos_platform_capability_parser.sv
// A last byte is held in the input register, then its result word is loaded
// into the result register. Throughput: one byte per cycle; a byte leaves the
// input register every cycle unless it is a last byte and the result register
// is full and not being taken. Reset: asynchronous, active low; clears the walk
// state, the input register valid and the result valid, and leaves it ready.
`include "bos_platform_capability_parser_assert.svh"

module bos_platform_capability_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        found,
    output logic [15:0] capability_version,
    output logic [7:0]  vendor_request_code,
    output logic [7:0]  landing_page_index
);

    logic             in_valid_reg;
    logic [7:0]       in_data_reg;
    logic             in_last_reg;
    logic             out_full;
    logic             out_room;
    logic             in_fire;
    logic             in_drain;
    logic             out_take;
    bpc_pkg::result_t scan_result;
    bpc_pkg::result_t out_word;

    // Handshake between the input register and the result register.
    assign out_take   = out_full && result_ready;
    assign out_room   = !out_full || result_ready;
    assign in_drain   = in_valid_reg && (!in_last_reg || out_room);
    assign byte_ready = !in_valid_reg || in_drain;
    assign in_fire    = byte_valid && byte_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_fire)
            in_valid_reg <= 1'b1;
        else if (in_drain)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // Header check and capability walk.
    bpc_scan u_scan
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_drain),
        .data   (in_data_reg),
        .last   (in_last_reg),
        .result (scan_result)
    );

    // Result register.
    bpc_out u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_drain && in_last_reg),
        .result (scan_result),
        .take   (out_take),
        .full   (out_full),
        .held   (out_word)
    );

    assign result_valid        = out_full;
    assign found               = out_word.found;
    assign capability_version  = out_word.version;
    assign vendor_request_code = out_word.vendor;
    assign landing_page_index  = out_word.landing;

    // A last byte that leaves the input register always yields a result word.
    `BPC_ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_drain && in_last_reg, result_valid,
        "last byte produced no result word")

    // A result word without a match carries all-zero fields.
    `BPC_ASSERT_SAME(a_zero_fields, clk, rst_n, result_valid && !found,
        capability_version == 16'd0 && vendor_request_code == 8'd0 &&
        landing_page_index == 8'd0, "unmatched result carries nonzero fields")

    // Back-pressure only comes from an occupied input register.
    `BPC_ASSERT_SAME(a_ready_cause, clk, rst_n, !byte_ready,
        in_valid_reg && in_last_reg && out_full && !result_ready,
        "input stalled without a blocked last byte")

endmodule

FILE: dv/bpc_tb_pkg.sv
package bpc_tb_pkg;

    import bpc_pkg::*;

    // WebUSB platform capability identifier, in the order it appears on the bus.
    localparam logic [7:0] WEBUSB_ID [16] = '{
        8'h38, 8'hB6, 8'h08, 8'h34, 8'hA9, 8'h09, 8'hA0, 8'h47,
        8'h8B, 8'hFD, 8'hA0, 8'h76, 8'h88, 8'h15, 8'hB6, 8'h65
    };

    // Tracks the descriptor walk word by word and holds the results that are still owed.
    class webusb_scoreboard;

        logic [15:0] byte_count;
        logic [15:0] declared_len;
        logic [7:0]  caps_left;
        logic [7:0]  cap_pos;
        logic [7:0]  cap_len;
        logic        in_platform;
        logic        id_match;
        logic [1:0]  verdict;
        logic [15:0] cap_version;
        logic [7:0]  cap_vendor;
        logic [7:0]  cap_landing;

        result_t     expected_results[$];
        int unsigned error_count;

        function new();
            error_count = 0;
            restart();
        endfunction

        // Return the walk to its state at the start of a buffer.
        function void restart();
            byte_count   = 16'd0;
            declared_len = 16'd0;
            caps_left    = 8'd0;
            cap_pos      = 8'd0;
            cap_len      = 8'd0;
            in_platform  = 1'b0;
            id_match     = 1'b1;
            verdict      = VERDICT_PENDING;
            cap_version  = 16'd0;
            cap_vendor   = 8'd0;
            cap_landing  = 8'd0;
        endfunction

        // One word that falls inside a capability descriptor.
        function void walk_capability_byte(int pos, logic [7:0] b);
            int off;
            off = int'(cap_pos);
            if (off == int'(OFF_LENGTH))
            begin
                cap_len = b;
                if (b < CAP_MIN_LENGTH || int'(b) > int'(declared_len) - pos)
                begin
                    verdict = VERDICT_FAILED;
                    return;
                end
            end
            else if (off == int'(OFF_TYPE))
            begin
                if (b != CAP_DESC_TYPE)
                begin
                    verdict = VERDICT_FAILED;
                    return;
                end
            end
            else if (off == int'(OFF_CAPTYPE))
            begin
                in_platform = (b == CAP_TYPE_PLATFORM);
                if (in_platform && cap_len < PLATFORM_MIN_LEN)
                begin
                    verdict = VERDICT_FAILED;
                    return;
                end
            end
            else if (in_platform)
            begin
                if (off >= int'(OFF_UUID_LO) && off <= int'(OFF_UUID_HI))
                begin
                    if (b != WEBUSB_ID[off - int'(OFF_UUID_LO)])
                        id_match = 1'b0;
                    if (off == int'(OFF_UUID_HI))
                    begin
                        // A foreign platform capability is simply stepped over.
                        if (!id_match)
                        begin
                            in_platform = 1'b0;
                        end
                        else if (cap_len < WEBUSB_MIN_LEN)
                        begin
                            verdict = VERDICT_FAILED;
                            return;
                        end
                    end
                end
                else if (off == int'(OFF_VER_LO))
                begin
                    cap_version[7:0] = b;
                end
                else if (off == int'(OFF_VER_HI))
                begin
                    cap_version[15:8] = b;
                    if (cap_version < WEBUSB_MIN_VER)
                    begin
                        in_platform = 1'b0;
                    end
                    else if (cap_len != WEBUSB_LEN)
                    begin
                        verdict = VERDICT_FAILED;
                        return;
                    end
                end
                else if (off == int'(OFF_VENDOR))
                begin
                    cap_vendor = b;
                end
                else if (off == int'(OFF_LANDING))
                begin
                    cap_landing = b;
                    verdict = VERDICT_FOUND;
                    return;
                end
            end
            cap_pos = 8'(off + 1);
            // End of this capability: move on, unless none remain or the total is used up.
            if (cap_pos == cap_len)
            begin
                caps_left = caps_left - 8'd1;
                if (caps_left == 8'd0 || pos + 1 == int'(declared_len))
                begin
                    verdict = VERDICT_FAILED;
                    return;
                end
                cap_pos     = 8'd0;
                in_platform = 1'b0;
                id_match    = 1'b1;
            end
        endfunction

        // Note one accepted input word; the last word of a buffer owes one result.
        function void note_byte(logic [7:0] b, logic is_last);
            int      pos;
            logic    ok;
            result_t want;
            pos = int'(byte_count);
            if (verdict == VERDICT_PENDING)
            begin
                if (pos == 0)
                begin
                    if (b != BOS_HDR_LENGTH)
                        verdict = VERDICT_FAILED;
                end
                else if (pos == 1)
                begin
                    if (b != BOS_DESC_TYPE)
                        verdict = VERDICT_FAILED;
                end
                else if (pos == 2)
                begin
                    declared_len = {8'h00, b};
                end
                else if (pos == 3)
                begin
                    declared_len[15:8] = b;
                    if (declared_len < 16'd5)
                        verdict = VERDICT_FAILED;
                end
                else if (pos == 4)
                begin
                    caps_left = b;
                    if (b == 8'd0 || declared_len == 16'd5)
                        verdict = VERDICT_FAILED;
                end
                else if (pos < int'(declared_len))
                begin
                    walk_capability_byte(pos, b);
                end
            end
            if (byte_count != 16'hFFFF)
                byte_count = byte_count + 16'd1;
            if (is_last)
            begin
                ok = (verdict == VERDICT_FOUND) && (byte_count >= 16'd5) &&
                     (byte_count >= declared_len);
                want.found   = ok;
                want.version = ok ? cap_version : 16'd0;
                want.vendor  = ok ? cap_vendor : 8'd0;
                want.landing = ok ? cap_landing : 8'd0;
                expected_results.push_back(want);
                restart();
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                error_count++;
            end
        endfunction

        // Check one accepted result word against the oldest prediction.
        function void check_result(logic f, logic [15:0] ver, logic [7:0] vend,
                                   logic [7:0] land);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result word arrived with no prediction waiting");
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("found", 16'(want.found), 16'(f));
            compare_field("capability_version", want.version, ver);
            compare_field("vendor_request_code", 16'(want.vendor), 16'(vend));
            compare_field("landing_page_index", 16'(want.landing), 16'(land));
        endfunction

    endclass

endpackage

FILE: dv/tb_bos_platform_capability_parser.sv
module tb_bos_platform_capability_parser;

    import bpc_pkg::*;
    import bpc_tb_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_BYTES    = 1000;
    localparam int CALM_AFTER      = 850;
    localparam int MIN_FRAMES      = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        found;
    logic [15:0] capability_version;
    logic [7:0]  vendor_request_code;
    logic [7:0]  landing_page_index;

    webusb_scoreboard sb = new();

    logic [7:0]  frame_q[$];
    int unsigned bytes_sent = 0;
    int unsigned quiet_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_off_req = 1'b0;

    bos_platform_capability_parser u_top
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .byte_valid          (byte_valid),
        .byte_ready          (byte_ready),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .found               (found),
        .capability_version  (capability_version),
        .vendor_request_code (vendor_request_code),
        .landing_page_index  (landing_page_index)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Offer one word, after an occasional idle burst, and wait until the block takes it.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int unsigned gap;
        if (!calm && $urandom_range(0, 15) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            byte_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        data_byte  <= value;
        last_byte  <= is_last;
        do @(posedge clk); while (!byte_ready);
        sb.note_byte(value, is_last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // BOS header with a capability count; the total length is patched in later.
    task automatic begin_frame(input logic [7:0] ncaps);
        frame_q.delete();
        frame_q.push_back(BOS_HDR_LENGTH);
        frame_q.push_back(BOS_DESC_TYPE);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        frame_q.push_back(ncaps);
    endtask

    task automatic set_total(input logic [15:0] total);
        frame_q[2] = total[7:0];
        frame_q[3] = total[15:8];
    endtask

    task automatic seal_frame();
        set_total(16'(frame_q.size()));
    endtask

    // A capability of the given kind with random payload.
    task automatic add_plain_cap(input logic [7:0] len, input logic [7:0] kind);
        frame_q.push_back(len);
        frame_q.push_back(CAP_DESC_TYPE);
        frame_q.push_back(kind);
        for (int off = 3; off < int'(len); off++)
            frame_q.push_back(rand_byte());
    endtask

    // A platform capability of the given length; id_ok picks the WebUSB identifier
    // or one with a single corrupted byte.
    task automatic add_platform_cap(input logic [7:0] len, input logic id_ok,
                                    input logic [15:0] ver, input logic [7:0] vend,
                                    input logic [7:0] land);
        int bad;
        bad = $urandom_range(int'(OFF_UUID_LO), int'(OFF_UUID_HI));
        for (int off = 0; off < int'(len); off++)
        begin
            if (off == int'(OFF_LENGTH))
                frame_q.push_back(len);
            else if (off == int'(OFF_TYPE))
                frame_q.push_back(CAP_DESC_TYPE);
            else if (off == int'(OFF_CAPTYPE))
                frame_q.push_back(CAP_TYPE_PLATFORM);
            else if (off >= int'(OFF_UUID_LO) && off <= int'(OFF_UUID_HI))
                frame_q.push_back((!id_ok && off == bad) ?
                    WEBUSB_ID[off - int'(OFF_UUID_LO)] ^ 8'($urandom_range(1, 255)) :
                    WEBUSB_ID[off - int'(OFF_UUID_LO)]);
            else if (off == int'(OFF_VER_LO))
                frame_q.push_back(ver[7:0]);
            else if (off == int'(OFF_VER_HI))
                frame_q.push_back(ver[15:8]);
            else if (off == int'(OFF_VENDOR))
                frame_q.push_back(vend);
            else if (off == int'(OFF_LANDING))
                frame_q.push_back(land);
            else
                frame_q.push_back(rand_byte());
        end
    endtask

    // A well-formed buffer holding a single WebUSB capability.
    task automatic good_frame(input logic [15:0] ver, input logic [7:0] vend,
                              input logic [7:0] land);
        begin_frame(8'd1);
        add_platform_cap(WEBUSB_LEN, 1'b1, ver, vend, land);
        seal_frame();
    endtask

    // Mostly well-formed buffers with random content, plus broken ones and noise.
    task automatic random_frame();
        int          kind;
        int          ncaps;
        int          pick;
        logic [7:0]  count;
        logic [15:0] ver;
        logic [7:0]  len;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            ncaps = $urandom_range(1, 4);
            pick  = $urandom_range(0, 9);
            if (pick == 0)
                count = 8'd0;
            else if (pick == 1)
                count = 8'(ncaps + $urandom_range(1, 3));
            else if (pick == 2)
                count = rand_byte();
            else
                count = 8'(ncaps);
            begin_frame(count);
            for (int i = 0; i < ncaps; i++)
            begin
                pick = $urandom_range(0, 5);
                if (pick < 2)
                begin
                    add_plain_cap(8'($urandom_range(3, 12)), rand_byte());
                end
                else if (pick == 2)
                begin
                    add_platform_cap(8'($urandom_range(20, 28)), 1'b0, 16'($urandom),
                                     rand_byte(), rand_byte());
                end
                else
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        ver = 16'($urandom_range(16'h0100, 16'hFFFF));
                        len = ($urandom_range(0, 3) == 0) ?
                              8'($urandom_range(22, 26)) : WEBUSB_LEN;
                    end
                    else
                    begin
                        ver = 16'($urandom_range(0, 16'h00FF));
                        len = 8'($urandom_range(22, 28));
                    end
                    add_platform_cap(len, 1'b1, ver, rand_byte(), rand_byte());
                end
            end
            seal_frame();
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 8)) frame_q.push_back(rand_byte());
            if ($urandom_range(0, 7) == 0)
                frame_q[$urandom_range(0, frame_q.size() - 1)] = rand_byte();
            if ($urandom_range(0, 7) == 0)
            begin
                pick = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > pick)
                    void'(frame_q.pop_back());
            end
        end
        else if (kind < 9)
        begin
            // Valid header start with a random count and a small random total.
            begin_frame(rand_byte());
            set_total(16'($urandom_range(0, 40)));
            repeat ($urandom_range(0, 30)) frame_q.push_back(rand_byte());
        end
        else
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 12)) frame_q.push_back(rand_byte());
        end
        send_frame();
    endtask

    // Main stimulus: reset, directed buffers, back-pressure, then random buffers.
    initial
    begin : stimulus
        int unsigned rand_start;
        int unsigned frames;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Matching capability at the low and high extremes of its fields.
        good_frame(WEBUSB_MIN_VER, 8'h01, 8'h01);
        send_frame();
        begin_frame(8'hFF);
        add_platform_cap(WEBUSB_LEN, 1'b1, 16'hFFFF, 8'hFF, 8'hFF);
        seal_frame();
        send_frame();

        // Another capability first, then the match with zero vendor code and page.
        begin_frame(8'd2);
        add_plain_cap(8'd7, 8'h02);
        add_platform_cap(WEBUSB_LEN, 1'b1, WEBUSB_MIN_VER, 8'h00, 8'h00);
        seal_frame();
        send_frame();

        // Foreign platform capability is skipped.
        begin_frame(8'd2);
        add_platform_cap(8'd28, 1'b0, 16'h0200, 8'h11, 8'h22);
        add_platform_cap(WEBUSB_LEN, 1'b1, 16'h0210, 8'h5A, 8'hA5);
        seal_frame();
        send_frame();

        // Pre-1.0 version is skipped, then a proper match.
        begin_frame(8'd2);
        add_platform_cap(WEBUSB_MIN_LEN, 1'b1, 16'h00FF, 8'h00, 8'h00);
        add_platform_cap(WEBUSB_LEN, 1'b1, WEBUSB_MIN_VER, 8'h33, 8'h44);
        seal_frame();
        send_frame();

        // Only a pre-1.0 capability: runs out of capabilities.
        begin_frame(8'd1);
        add_platform_cap(WEBUSB_MIN_LEN, 1'b1, 16'h0000, 8'h00, 8'h00);
        seal_frame();
        send_frame();

        // Buffer shorter than the header.
        frame_q.delete();
        frame_q.push_back(BOS_HDR_LENGTH);
        frame_q.push_back(BOS_DESC_TYPE);
        frame_q.push_back(8'h20);
        send_frame();

        // Match found but fewer words received than the declared total.
        good_frame(16'h0101, 8'h10, 8'h20);
        set_total(16'(frame_q.size() + 10));
        send_frame();

        // Words past the total length are only counted.
        good_frame(16'h0102, 8'h30, 8'h40);
        repeat (6) frame_q.push_back(rand_byte());
        send_frame();

        // Capability count of zero.
        begin_frame(8'd0);
        add_platform_cap(WEBUSB_LEN, 1'b1, WEBUSB_MIN_VER, 8'h01, 8'h02);
        seal_frame();
        send_frame();

        // Capabilities still expected when the total is reached.
        begin_frame(8'd3);
        add_plain_cap(8'd9, 8'h03);
        seal_frame();
        send_frame();

        // Bad header length, then bad descriptor type: decided early.
        good_frame(WEBUSB_MIN_VER, 8'h01, 8'h01);
        frame_q[0] = 8'h06;
        send_frame();
        good_frame(WEBUSB_MIN_VER, 8'h01, 8'h01);
        frame_q[1] = 8'h0E;
        send_frame();

        // Total length below the header size, and exactly the header size.
        begin_frame(8'd1);
        set_total(16'd4);
        repeat (3) frame_q.push_back(rand_byte());
        send_frame();
        begin_frame(8'd1);
        seal_frame();
        send_frame();

        // Capability too short, longer than the total, and of the wrong type.
        begin_frame(8'd1);
        add_plain_cap(8'd2, 8'h02);
        seal_frame();
        send_frame();
        begin_frame(8'd1);
        add_plain_cap(8'd10, 8'h02);
        seal_frame();
        frame_q[5] = 8'd200;
        send_frame();
        good_frame(WEBUSB_MIN_VER, 8'h01, 8'h01);
        frame_q[6] = 8'h11;
        send_frame();

        // Platform too short, WebUSB too short, and a 1.0 capability of wrong length.
        begin_frame(8'd1);
        add_platform_cap(8'd19, 1'b1, WEBUSB_MIN_VER, 8'h00, 8'h00);
        seal_frame();
        send_frame();
        begin_frame(8'd1);
        add_platform_cap(8'd21, 1'b1, WEBUSB_MIN_VER, 8'h00, 8'h00);
        seal_frame();
        send_frame();
        begin_frame(8'd1);
        add_platform_cap(8'd25, 1'b1, WEBUSB_MIN_VER, 8'h55, 8'h66);
        seal_frame();
        send_frame();

        // Single-word buffers.
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();
        frame_q[0] = 8'hFF;
        send_frame();

        // Largest declared total with a buffer far shorter than it.
        good_frame(16'h0123, 8'h77, 8'h88);
        set_total(16'hFFFF);
        send_frame();

        // The receiver holds off while short buffers keep coming, so the block backs up.
        hold_off_req = 1'b1;
        repeat (30)
        begin
            frame_q.delete();
            frame_q.push_back(rand_byte());
            send_frame();
        end

        rand_start = bytes_sent;
        frames     = 0;
        while (bytes_sent - rand_start < RANDOM_BYTES || frames < MIN_FRAMES)
        begin
            if (bytes_sent - rand_start >= CALM_AFTER)
                calm = 1'b1;
            random_frame();
            frames++;
        end

        @(negedge clk);
        byte_valid <= 1'b0;

        // Drain the remaining results, then allow for anything unexpected.
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                result_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 16);
                result_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Check every accepted result word.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(found, capability_version, vendor_request_code,
                            landing_page_index);
    end

    // End the run if neither side moves a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_scan.sv
rtl/bpc_out.sv
rtl/bos_platform_capability_parser.sv
dv/bpc_tb_pkg.sv
dv/tb_bos_platform_capability_parser.sv
